@@ sv/button_hold_time_tracker_unit_defines.svh @@
// Assertion macros shared by the button hold-time tracker RTL.
// Depends on nothing; define ASSERT_OFF to drop every check.
`ifndef BUTTON_HOLD_TIME_TRACKER_UNIT_DEFINES_SVH
`define BUTTON_HOLD_TIME_TRACKER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ sv/btt_pkg.sv @@
// Types and constants of the button hold-time tracker.
// Used by btt_div and button_hold_time_tracker_unit.
`default_nettype none
package btt_pkg;
    localparam int NUM_BUTTONS = 16;
    localparam int BTN_CNT_W   = 7;
    localparam int MODE_W      = 2;
    localparam int IDX_W       = 4;
    localparam int KEY_W       = 9;
    localparam int SLOT_W      = 10;
    localparam int TIME_W      = 32;
    localparam int FLEN_W      = 8;
    localparam int FRAC_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int QUOT_W      = 15;
    localparam int DIV_STEPS   = 15;
    localparam int CNT_W       = 4;

    localparam logic [SLOT_W-1:0] MANUAL_CODE = 10'h3FF;
    localparam logic [SLOT_W-1:0] EMPTY_CODE  = 10'h000;
    localparam logic [FLEN_W-1:0] FRAME_CAP   = 8'd200;
    localparam logic [FRAC_W-1:0] ONE_Q15     = 16'h8000;

    typedef enum logic [MODE_W-1:0] {
        MODE_PRESS   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_SAMPLE  = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STS_APPLIED   = 3'd0,
        STS_REPEAT    = 3'd1,
        STS_THIRD     = 3'd2,
        STS_UNMATCHED = 3'd3,
        STS_SAMPLED   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLASS,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [FLEN_W-1:0] num;
        logic [FLEN_W-1:0] den;
    } t_div_req;
endpackage
`default_nettype wire

@@ sv/btt_div.sv @@
// Iterative restoring divider: (num << 15) / den, one quotient bit a cycle.
// Requires num < den; depends on btt_pkg and the assertion macro header.
`default_nettype none
`include "button_hold_time_tracker_unit_defines.svh"
module btt_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire btt_pkg::t_div_req      i_req,
    output logic                        o_done,
    output logic [btt_pkg::QUOT_W-1:0]  o_quot
);
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [btt_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [btt_pkg::FLEN_W-1:0]    r_rem, n_rem;
    logic [btt_pkg::FLEN_W-1:0]    r_den, n_den;
    logic [btt_pkg::QUOT_W-1:0]    r_quot, n_quot;
    logic [btt_pkg::FLEN_W:0]      shifted;
    logic [btt_pkg::FLEN_W:0]      diff;
    logic                          take;

    always_comb begin
        shifted = {r_rem, 1'b0};
        diff    = shifted - {1'b0, r_den};
        take    = (shifted >= {1'b0, r_den});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quot  = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = btt_pkg::CNT_W'(btt_pkg::DIV_STEPS);
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = take ? diff[btt_pkg::FLEN_W-1:0] : shifted[btt_pkg::FLEN_W-1:0];
            n_quot = {r_quot[btt_pkg::QUOT_W-2:0], take};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == btt_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `ASSERT_PROP(a_start_busy, i_clk, i_rst_n, i_req.start |=> r_busy)
    `ASSERT_PROP(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done)
    `ASSERT_PROP(a_rem_below, i_clk, i_rst_n, r_busy |-> (r_rem < r_den))
    `ASSERT_NEVER(a_busy_cnt, i_clk, i_rst_n, r_busy && (r_cnt == '0))
endmodule
`default_nettype wire

@@ sv/button_hold_time_tracker_unit.sv @@
// Button hold-time tracker: per-button key slots, down stamps and held time,
// with a small sequencer over a shared divider. Depends on btt_pkg, btt_div.
//
// Each transaction yields exactly one result. A press, a release or an
// unknown mode passes through S_EXEC and then S_DONE. A frame sample for a
// button in range that needs a division passes through S_EXEC, S_CLASS, S_DIV
// and S_DONE, with the 15 quotient bits of the shared divider forming the
// held fraction of the frame; a sample without a division (zero frame length,
// no positive time or a full frame) skips S_DIV. The unit takes one transaction
// at a time; the result sits in an output register, so the next transaction
// may be taken while the previous result waits for the consumer, and it
// stalls before its result for as long as that result still waits.
`default_nettype none
`include "button_hold_time_tracker_unit_defines.svh"
module button_hold_time_tracker_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [btt_pkg::MODE_W-1:0]     i_mode,
    input  wire  [btt_pkg::IDX_W-1:0]      i_button_index,
    input  wire                            i_has_key,
    input  wire  [btt_pkg::KEY_W-1:0]      i_key_code,
    input  wire  [btt_pkg::TIME_W-1:0]     i_event_time,
    input  wire  [btt_pkg::FLEN_W-1:0]     i_frame_length,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [btt_pkg::IDX_W-1:0]      o_button_echo,
    output logic [btt_pkg::FRAC_W-1:0]     o_fraction,
    output logic                           o_is_active,
    output logic                           o_held_or_pressed,
    output logic [btt_pkg::STATUS_W-1:0]   o_status
);
    btt_pkg::t_state               r_state, n_state;

    logic [btt_pkg::MODE_W-1:0]    r_mode;
    logic [btt_pkg::IDX_W-1:0]     r_idx;
    logic                          r_has_key;
    logic [btt_pkg::KEY_W-1:0]     r_key;
    logic [btt_pkg::TIME_W-1:0]    r_time;
    logic [btt_pkg::FLEN_W-1:0]    r_flen;

    logic [btt_pkg::SLOT_W-1:0]    r_first  [btt_pkg::NUM_BUTTONS];
    logic [btt_pkg::SLOT_W-1:0]    r_second [btt_pkg::NUM_BUTTONS];
    logic [btt_pkg::TIME_W-1:0]    r_down   [btt_pkg::NUM_BUTTONS];
    logic [btt_pkg::TIME_W-1:0]    r_held   [btt_pkg::NUM_BUTTONS];
    logic                          r_act    [btt_pkg::NUM_BUTTONS];
    logic                          r_prs    [btt_pkg::NUM_BUTTONS];
    logic [btt_pkg::FLEN_W-1:0]    r_last_flen, n_last_flen;

    logic [btt_pkg::SLOT_W-1:0]    n_first, n_second;
    logic [btt_pkg::TIME_W-1:0]    n_down, n_held;
    logic                          n_act, n_prs;
    logic                          wr_en;

    logic [btt_pkg::TIME_W-1:0]    r_m, n_m;
    logic [btt_pkg::FLEN_W-1:0]    r_fsat, n_fsat;

    logic [btt_pkg::IDX_W-1:0]     r_res_idx, n_res_idx;
    logic [btt_pkg::FRAC_W-1:0]    r_res_frac, n_res_frac;
    logic                          r_res_act, n_res_act;
    logic                          r_res_hop, n_res_hop;
    btt_pkg::t_status              r_res_status, n_res_status;

    logic                          r_out_valid, n_out_valid;
    logic [btt_pkg::IDX_W-1:0]     r_out_idx, n_out_idx;
    logic [btt_pkg::FRAC_W-1:0]    r_out_frac, n_out_frac;
    logic                          r_out_act, n_out_act;
    logic                          r_out_hop, n_out_hop;
    btt_pkg::t_status              r_out_status, n_out_status;

    btt_pkg::t_div_req             div_req;
    logic                          div_done;
    logic [btt_pkg::QUOT_W-1:0]    div_quot;

    logic                          in_range;
    logic [btt_pkg::SLOT_W-1:0]    code;
    logic [btt_pkg::SLOT_W-1:0]    s1, s2;
    logic [btt_pkg::TIME_W-1:0]    dn, hd;
    logic                          act, prs;
    logic                          accept;
    logic                          m_pos;

    btt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign in_range = (btt_pkg::BTN_CNT_W'(r_idx) < btt_pkg::BTN_CNT_W'(btt_pkg::NUM_BUTTONS));
    assign code     = r_has_key ? {1'b0, r_key} : btt_pkg::MANUAL_CODE;
    assign s1       = r_first[r_idx];
    assign s2       = r_second[r_idx];
    assign dn       = r_down[r_idx];
    assign hd       = r_held[r_idx];
    assign act      = r_act[r_idx];
    assign prs      = r_prs[r_idx];
    assign m_pos    = !r_m[btt_pkg::TIME_W-1] && (r_m != '0);

    always_comb begin
        n_state      = r_state;
        o_in_ready   = (r_state == btt_pkg::S_IDLE);
        wr_en        = 1'b0;
        n_first      = s1;
        n_second     = s2;
        n_down       = dn;
        n_held       = hd;
        n_act        = act;
        n_prs        = prs;
        n_last_flen  = r_last_flen;
        n_m          = r_m;
        n_fsat       = r_fsat;
        n_res_idx    = r_res_idx;
        n_res_frac   = r_res_frac;
        n_res_act    = r_res_act;
        n_res_hop    = r_res_hop;
        n_res_status = r_res_status;
        div_req      = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_idx    = r_out_idx;
        n_out_frac   = r_out_frac;
        n_out_act    = r_out_act;
        n_out_hop    = r_out_hop;
        n_out_status = r_out_status;

        case (r_state)
            btt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = btt_pkg::S_EXEC;
                end
            end
            btt_pkg::S_EXEC: begin
                n_res_idx    = r_idx;
                n_res_frac   = '0;
                n_res_hop    = 1'b0;
                n_res_status = btt_pkg::STS_APPLIED;
                n_state      = btt_pkg::S_DONE;
                if (in_range) begin
                    wr_en = 1'b1;
                    case (btt_pkg::t_mode'(r_mode))
                        btt_pkg::MODE_PRESS: begin
                            if (code == s1 || code == s2) begin
                                n_res_status = btt_pkg::STS_REPEAT;
                            end else if (s1 == btt_pkg::EMPTY_CODE) begin
                                n_first = code;
                            end else if (s2 == btt_pkg::EMPTY_CODE) begin
                                n_second = code;
                            end else begin
                                n_res_status = btt_pkg::STS_THIRD;
                            end
                            if (n_res_status == btt_pkg::STS_APPLIED && !act) begin
                                n_down = r_time;
                                n_act  = 1'b1;
                                n_prs  = 1'b1;
                            end
                        end
                        btt_pkg::MODE_RELEASE: begin
                            if (!r_has_key) begin
                                n_first  = btt_pkg::EMPTY_CODE;
                                n_second = btt_pkg::EMPTY_CODE;
                                n_act    = 1'b0;
                            end else begin
                                if (s1 == code) begin
                                    n_first = btt_pkg::EMPTY_CODE;
                                end else if (s2 == code) begin
                                    n_second = btt_pkg::EMPTY_CODE;
                                end else begin
                                    n_res_status = btt_pkg::STS_UNMATCHED;
                                end
                                if (n_res_status == btt_pkg::STS_APPLIED &&
                                    n_first == btt_pkg::EMPTY_CODE &&
                                    n_second == btt_pkg::EMPTY_CODE) begin
                                    n_act = 1'b0;
                                    if (r_time != '0) begin
                                        n_held = hd + (r_time - dn);
                                    end else begin
                                        n_held = hd + btt_pkg::TIME_W'(r_last_flen[btt_pkg::FLEN_W-1:1]);
                                    end
                                end
                            end
                        end
                        btt_pkg::MODE_SAMPLE: begin
                            n_res_hop    = act || prs;
                            n_res_status = btt_pkg::STS_SAMPLED;
                            n_prs        = 1'b0;
                            n_held       = '0;
                            n_fsat       = (r_flen > btt_pkg::FRAME_CAP) ? btt_pkg::FRAME_CAP : r_flen;
                            n_last_flen  = n_fsat;
                            n_m          = hd;
                            if (act) begin
                                n_m    = (dn == '0) ? r_time : hd + (r_time - dn);
                                n_down = r_time;
                            end
                            n_state = btt_pkg::S_CLASS;
                        end
                        default: begin
                            wr_en = 1'b0;
                        end
                    endcase
                    n_res_act = n_act;
                end else begin
                    n_res_act = 1'b0;
                end
            end
            btt_pkg::S_CLASS: begin
                n_state = btt_pkg::S_DONE;
                if (r_fsat == '0) begin
                    n_res_frac = m_pos ? btt_pkg::ONE_Q15 : '0;
                end else if (!m_pos) begin
                    n_res_frac = '0;
                end else if (r_m >= btt_pkg::TIME_W'(r_fsat)) begin
                    n_res_frac = btt_pkg::ONE_Q15;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = r_m[btt_pkg::FLEN_W-1:0];
                    div_req.den   = r_fsat;
                    n_state       = btt_pkg::S_DIV;
                end
            end
            btt_pkg::S_DIV: begin
                if (div_done) begin
                    n_res_frac = btt_pkg::FRAC_W'(div_quot);
                    n_state    = btt_pkg::S_DONE;
                end
            end
            btt_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_res_idx;
                    n_out_frac   = r_res_frac;
                    n_out_act    = r_res_act;
                    n_out_hop    = r_res_hop;
                    n_out_status = r_res_status;
                    n_state      = btt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = btt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= btt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode    <= i_mode;
            r_idx     <= i_button_index;
            r_has_key <= i_has_key;
            r_key     <= i_key_code;
            r_time    <= i_event_time;
            r_flen    <= i_frame_length;
        end
        r_m          <= n_m;
        r_fsat       <= n_fsat;
        r_res_idx    <= n_res_idx;
        r_res_frac   <= n_res_frac;
        r_res_act    <= n_res_act;
        r_res_hop    <= n_res_hop;
        r_res_status <= n_res_status;
        r_out_idx    <= n_out_idx;
        r_out_frac   <= n_out_frac;
        r_out_act    <= n_out_act;
        r_out_hop    <= n_out_hop;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < btt_pkg::NUM_BUTTONS; i++) begin
                r_first[i]  <= '0;
                r_second[i] <= '0;
                r_down[i]   <= '0;
                r_held[i]   <= '0;
                r_act[i]    <= 1'b0;
                r_prs[i]    <= 1'b0;
            end
            r_last_flen <= '0;
        end else begin
            if (wr_en) begin
                r_first[r_idx]  <= n_first;
                r_second[r_idx] <= n_second;
                r_down[r_idx]   <= n_down;
                r_held[r_idx]   <= n_held;
                r_act[r_idx]    <= n_act;
                r_prs[r_idx]    <= n_prs;
            end
            r_last_flen <= n_last_flen;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_button_echo     = r_out_idx;
    assign o_fraction        = r_out_frac;
    assign o_is_active       = r_out_act;
    assign o_held_or_pressed = r_out_hop;
    assign o_status          = r_out_status;

    `ASSERT_PROP(a_accept_exec, i_clk, i_rst_n, accept |=> (r_state == btt_pkg::S_EXEC))
    `ASSERT_PROP(a_frac_cap, i_clk, i_rst_n, r_out_valid |-> (r_out_frac <= btt_pkg::ONE_Q15))
    `ASSERT_PROP(a_hop_sample, i_clk, i_rst_n,
        (r_out_valid && r_out_status != btt_pkg::STS_SAMPLED) |-> !r_out_hop)
    `ASSERT_NEVER(a_div_state, i_clk, i_rst_n, div_done && (r_state != btt_pkg::S_DIV))
endmodule
`default_nettype wire

@@ test/button_hold_time_tracker_unit_test.sv @@
// Self-checking testbench for button_hold_time_tracker_unit: directed and random
// press, release and frame-sample transactions with random idling on both sides.
// Depends on btt_pkg and the unit RTL; predicts each result with its own model.
`default_nettype none
module button_hold_time_tracker_unit_test;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [btt_pkg::IDX_W-1:0]  echo;
        logic [btt_pkg::FRAC_W-1:0] fraction;
        logic                       active;
        logic                       hop;
        btt_pkg::t_status           status;
    } t_tracker_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [btt_pkg::MODE_W-1:0]    i_mode = '0;
    logic [btt_pkg::IDX_W-1:0]     i_button_index = '0;
    logic                          i_has_key = 1'b0;
    logic [btt_pkg::KEY_W-1:0]     i_key_code = '0;
    logic [btt_pkg::TIME_W-1:0]    i_event_time = '0;
    logic [btt_pkg::FLEN_W-1:0]    i_frame_length = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [btt_pkg::IDX_W-1:0]     o_button_echo;
    logic [btt_pkg::FRAC_W-1:0]    o_fraction;
    logic                          o_is_active;
    logic                          o_held_or_pressed;
    logic [btt_pkg::STATUS_W-1:0]  o_status;

    logic [btt_pkg::SLOT_W-1:0]    slot_a [btt_pkg::NUM_BUTTONS];
    logic [btt_pkg::SLOT_W-1:0]    slot_b [btt_pkg::NUM_BUTTONS];
    logic [btt_pkg::TIME_W-1:0]    down_ms [btt_pkg::NUM_BUTTONS];
    logic [btt_pkg::TIME_W-1:0]    held_acc [btt_pkg::NUM_BUTTONS];
    logic                          active_q [btt_pkg::NUM_BUTTONS];
    logic                          pressed_q [btt_pkg::NUM_BUTTONS];
    logic [btt_pkg::FLEN_W-1:0]    frame_len_q = '0;

    t_tracker_result               pending_results [$];
    logic [btt_pkg::TIME_W-1:0]    now_ms = '0;
    bit                            quiet_mode = 1'b0;
    int                            error_count = 0;
    int                            items_sent = 0;
    int                            results_seen = 0;
    int                            samples_sent = 0;
    int                            cycle_count = 0;
    int                            out_hold = 0;

    button_hold_time_tracker_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_button_index   (i_button_index),
        .i_has_key        (i_has_key),
        .i_key_code       (i_key_code),
        .i_event_time     (i_event_time),
        .i_frame_length   (i_frame_length),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_button_echo    (o_button_echo),
        .o_fraction       (o_fraction),
        .o_is_active      (o_is_active),
        .o_held_or_pressed(o_held_or_pressed),
        .o_status         (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (quiet_mode) begin
            return 0;
        end
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic t_tracker_result track_button_event(
        input btt_pkg::t_mode md, input logic [btt_pkg::IDX_W-1:0] idx, input logic hk,
        input logic [btt_pkg::KEY_W-1:0] key, input logic [btt_pkg::TIME_W-1:0] t,
        input logic [btt_pkg::FLEN_W-1:0] flen
    );
        t_tracker_result                   r;
        logic [btt_pkg::SLOT_W-1:0]        code;
        logic [btt_pkg::TIME_W-1:0]        m;
        logic signed [btt_pkg::TIME_W-1:0] sm;
        longint                            lm;
        longint                            fl;
        int                                b;
        r = '0;
        r.echo = idx;
        r.status = btt_pkg::STS_APPLIED;
        code = hk ? {1'b0, key} : btt_pkg::MANUAL_CODE;
        b = int'(idx);
        if (b >= btt_pkg::NUM_BUTTONS) begin
            return r;
        end
        case (md)
            btt_pkg::MODE_PRESS: begin
                if (code == slot_a[b] || code == slot_b[b]) begin
                    r.status = btt_pkg::STS_REPEAT;
                end else if (slot_a[b] == btt_pkg::EMPTY_CODE ||
                             slot_b[b] == btt_pkg::EMPTY_CODE) begin
                    if (slot_a[b] == btt_pkg::EMPTY_CODE) begin
                        slot_a[b] = code;
                    end else begin
                        slot_b[b] = code;
                    end
                    if (!active_q[b]) begin
                        down_ms[b] = t;
                        active_q[b] = 1'b1;
                        pressed_q[b] = 1'b1;
                    end
                end else begin
                    r.status = btt_pkg::STS_THIRD;
                end
            end
            btt_pkg::MODE_RELEASE: begin
                if (!hk) begin
                    slot_a[b] = btt_pkg::EMPTY_CODE;
                    slot_b[b] = btt_pkg::EMPTY_CODE;
                    active_q[b] = 1'b0;
                end else if (slot_a[b] == code || slot_b[b] == code) begin
                    if (slot_a[b] == code) begin
                        slot_a[b] = btt_pkg::EMPTY_CODE;
                    end else begin
                        slot_b[b] = btt_pkg::EMPTY_CODE;
                    end
                    if (slot_a[b] == btt_pkg::EMPTY_CODE &&
                        slot_b[b] == btt_pkg::EMPTY_CODE) begin
                        active_q[b] = 1'b0;
                        if (t != '0) begin
                            held_acc[b] = held_acc[b] + (t - down_ms[b]);
                        end else begin
                            held_acc[b] = held_acc[b] + btt_pkg::TIME_W'(frame_len_q >> 1);
                        end
                    end
                end else begin
                    r.status = btt_pkg::STS_UNMATCHED;
                end
            end
            btt_pkg::MODE_SAMPLE: begin
                r.hop = active_q[b] | pressed_q[b];
                r.status = btt_pkg::STS_SAMPLED;
                pressed_q[b] = 1'b0;
                frame_len_q = (flen > btt_pkg::FRAME_CAP) ? btt_pkg::FRAME_CAP : flen;
                m = held_acc[b];
                held_acc[b] = '0;
                if (active_q[b]) begin
                    m = (down_ms[b] == '0) ? t : m + (t - down_ms[b]);
                    down_ms[b] = t;
                end
                sm = m;
                lm = sm;
                fl = frame_len_q;
                if (fl == 0) begin
                    r.fraction = (lm > 0) ? btt_pkg::ONE_Q15 : '0;
                end else if (lm <= 0) begin
                    r.fraction = '0;
                end else if (lm >= fl) begin
                    r.fraction = btt_pkg::ONE_Q15;
                end else begin
                    r.fraction = btt_pkg::FRAC_W'((lm * 32768) / fl);
                end
            end
            default: begin
            end
        endcase
        r.active = active_q[b];
        return r;
    endfunction

    task automatic send_item(
        input btt_pkg::t_mode md, input logic [btt_pkg::IDX_W-1:0] idx, input logic hk,
        input logic [btt_pkg::KEY_W-1:0] key, input logic [btt_pkg::TIME_W-1:0] t,
        input logic [btt_pkg::FLEN_W-1:0] flen
    );
        int gap;
        pending_results.push_back(track_button_event(md, idx, hk, key, t, flen));
        items_sent++;
        if (md == btt_pkg::MODE_SAMPLE) begin
            samples_sent++;
        end
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= md;
        i_button_index <= idx;
        i_has_key      <= hk;
        i_key_code     <= key;
        i_event_time   <= t;
        i_frame_length <= flen;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold <= 0;
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
            i_out_ready <= (out_hold == 1);
        end else if (o_out_valid && i_out_ready) begin
            gap = draw_wait();
            out_hold <= gap;
            i_out_ready <= (gap == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_tracker_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("transaction with nothing expected, button %0d",
                    o_button_echo));
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (o_button_echo !== want.echo) begin
                    report_mismatch($sformatf("button_echo got %0d expected %0d",
                        o_button_echo, want.echo));
                end
                if (o_fraction !== want.fraction) begin
                    report_mismatch($sformatf("button %0d fraction got %0d expected %0d",
                        want.echo, o_fraction, want.fraction));
                end
                if (o_is_active !== want.active) begin
                    report_mismatch($sformatf("button %0d is_active got %0b expected %0b",
                        want.echo, o_is_active, want.active));
                end
                if (o_held_or_pressed !== want.hop) begin
                    report_mismatch($sformatf("button %0d held_or_pressed got %0b expected %0b",
                        want.echo, o_held_or_pressed, want.hop));
                end
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("button %0d status got %0d expected %0d",
                        want.echo, o_status, want.status));
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_item(btt_pkg::MODE_SAMPLE, 4'd0, 1'b1, 9'd0, 32'd0, 8'd0);
        send_item(btt_pkg::MODE_PRESS, 4'd0, 1'b1, 9'd0, 32'd10, 8'd0);
        send_item(btt_pkg::MODE_RELEASE, 4'd0, 1'b1, 9'd0, 32'd100, 8'd0);
        send_item(btt_pkg::MODE_SAMPLE, 4'd0, 1'b1, 9'd0, 32'd50, 8'd255);
        send_item(btt_pkg::MODE_PRESS, 4'd15, 1'b1, 9'd511, 32'hFFFF_FFF0, 8'd0);
        send_item(btt_pkg::MODE_PRESS, 4'd15, 1'b0, 9'd0, 32'hFFFF_FFF8, 8'd0);
        send_item(btt_pkg::MODE_PRESS, 4'd15, 1'b1, 9'd17, 32'hFFFF_FFF9, 8'd0);
        send_item(btt_pkg::MODE_PRESS, 4'd15, 1'b1, 9'd511, 32'hFFFF_FFFA, 8'd0);
        send_item(btt_pkg::MODE_RELEASE, 4'd15, 1'b1, 9'd3, 32'hFFFF_FFFB, 8'd0);
        send_item(btt_pkg::MODE_SAMPLE, 4'd15, 1'b1, 9'd0, 32'h0000_0020, 8'd200);
        send_item(btt_pkg::MODE_RELEASE, 4'd15, 1'b1, 9'd511, 32'h0000_0030, 8'd0);
        send_item(btt_pkg::MODE_RELEASE, 4'd15, 1'b0, 9'd0, 32'h0000_0040, 8'd0);
        send_item(btt_pkg::MODE_SAMPLE, 4'd15, 1'b1, 9'd0, 32'd5, 8'd0);
        send_item(btt_pkg::MODE_PRESS, 4'd7, 1'b1, 9'd1, 32'd0, 8'd0);
        send_item(btt_pkg::MODE_SAMPLE, 4'd7, 1'b1, 9'd1, 32'd1000, 8'd100);
        send_item(btt_pkg::MODE_RELEASE, 4'd7, 1'b1, 9'd1, 32'd0, 8'd0);
        send_item(btt_pkg::MODE_SAMPLE, 4'd7, 1'b1, 9'd0, 32'd1, 8'd0);
        send_item(btt_pkg::MODE_PRESS, 4'd3, 1'b1, 9'd256, 32'd1000, 8'd0);
        send_item(btt_pkg::MODE_RELEASE, 4'd3, 1'b1, 9'd256, 32'd10, 8'd0);
        send_item(btt_pkg::MODE_SAMPLE, 4'd3, 1'b1, 9'd0, 32'd0, 8'd150);
        send_item(btt_pkg::MODE_NONE, 4'd3, 1'b1, 9'h155, 32'hAAAA_5555, 8'hAA);
        send_item(btt_pkg::MODE_NONE, 4'd15, 1'b0, 9'h0AA, 32'h5555_AAAA, 8'h55);
        send_item(btt_pkg::MODE_PRESS, 4'd8, 1'b0, 9'd0, 32'hFFFF_FFFF, 8'd0);
        send_item(btt_pkg::MODE_SAMPLE, 4'd8, 1'b1, 9'd0, 32'hFFFF_FFFF, 8'd1);
        send_item(btt_pkg::MODE_NONE, 4'd8, 1'b1, 9'd0, 32'd0, 8'd0);
    endtask

    task automatic run_hold_sessions(input int count, input bit wild);
        int                         n;
        int                         pick;
        logic [btt_pkg::IDX_W-1:0]  b;
        btt_pkg::t_mode             md;
        logic                       hk;
        logic [btt_pkg::KEY_W-1:0]  key;
        logic [btt_pkg::TIME_W-1:0] t;
        logic [btt_pkg::FLEN_W-1:0] fl;
        logic [btt_pkg::SLOT_W-1:0] held_code;
        for (n = 0; n < count; n++) begin
            now_ms = now_ms + $urandom_range(0, 120);
            if ($urandom_range(0, 49) == 0) begin
                now_ms = now_ms + $urandom;
            end
            b = ($urandom_range(0, 9) < 7) ? btt_pkg::IDX_W'($urandom_range(0, 3))
                                          : btt_pkg::IDX_W'($urandom_range(0, 15));
            hk = 1'b1;
            key = btt_pkg::KEY_W'($urandom_range(1, 6));
            t = now_ms;
            fl = btt_pkg::FLEN_W'($urandom_range(8, 60));
            pick = $urandom_range(0, 99);
            if (wild) begin
                md = btt_pkg::t_mode'($urandom_range(0, 3));
                hk = 1'($urandom_range(0, 1));
                key = btt_pkg::KEY_W'($urandom);
                t = $urandom;
                fl = btt_pkg::FLEN_W'($urandom);
            end else if (pick < 32) begin
                md = btt_pkg::MODE_PRESS;
                if ($urandom_range(0, 9) == 0) begin
                    hk = 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    key = btt_pkg::KEY_W'($urandom_range(0, 511));
                end
            end else if (pick < 60) begin
                md = btt_pkg::MODE_RELEASE;
                held_code = slot_a[b];
                if (held_code == btt_pkg::EMPTY_CODE ||
                    ($urandom_range(0, 1) == 1 && slot_b[b] != btt_pkg::EMPTY_CODE)) begin
                    held_code = slot_b[b];
                end
                if (held_code == btt_pkg::MANUAL_CODE || $urandom_range(0, 19) == 0) begin
                    hk = 1'b0;
                end else if (held_code != btt_pkg::EMPTY_CODE &&
                             $urandom_range(0, 9) != 0) begin
                    key = held_code[btt_pkg::KEY_W-1:0];
                end
            end else if (pick < 92) begin
                md = btt_pkg::MODE_SAMPLE;
                case ($urandom_range(0, 9))
                    0: fl = '0;
                    1: fl = btt_pkg::FLEN_W'($urandom_range(200, 255));
                    2: fl = 8'd1;
                    default: begin
                    end
                endcase
            end else begin
                md = btt_pkg::MODE_NONE;
                key = btt_pkg::KEY_W'($urandom);
            end
            if (!wild && $urandom_range(0, 19) == 0) begin
                t = '0;
            end
            send_item(md, b, hk, key, t, fl);
        end
    endtask

    task automatic test_drain_pressure();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_idle_sessions();
        quiet_mode = 1'b0;
        run_hold_sessions(400, 1'b0);
    endtask

    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        run_hold_sessions(300, 1'b0);
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_noise();
        run_hold_sessions(150, 1'b1);
        run_hold_sessions(150, 1'b0);
    endtask

    initial begin
        for (int i = 0; i < btt_pkg::NUM_BUTTONS; i++) begin
            slot_a[i] = btt_pkg::EMPTY_CODE;
            slot_b[i] = btt_pkg::EMPTY_CODE;
            down_ms[i] = '0;
            held_acc[i] = '0;
            active_q[i] = 1'b0;
            pressed_q[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_idle_sessions();
        test_drain_pressure();
        test_back_to_back();
        test_random_noise();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (25) @(posedge i_clk);
        $display("covered %0d transactions (%0d frame samples), %0d results checked,",
            items_sent, samples_sent, results_seen);
        $display("keyed and manual holds, repeats, third keys, wraps and frame clamps");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/btt_pkg.sv
sv/btt_div.sv
sv/button_hold_time_tracker_unit.sv
test/button_hold_time_tracker_unit_test.sv
